@@ hdl/sha256_byte_stream_hasher_macros.svh @@
// assertion macros used by the sha256 hasher controller
// no dependencies
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/sha_pkg.sv @@
// shared types, constants and round functions for the sha256 hasher
// no dependencies
`default_nettype none
package sha_pkg;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  // controller commands to the datapath
  typedef struct packed {
    logic       wr_en;      // write byte into block store
    logic [1:0] wr_sel;     // byte source
    logic [2:0] len_idx;    // length byte index
    logic       len_add;    // add 8 to bit count
    logic       len_clr;    // clear bit count, capture
    logic       cmp_start;  // load round vars from chain, fetch store word 0
    logic       rnd_en;     // run one round
    logic       cmp_fin;    // add round vars into chain
    logic       chain_init; // restore initial hash
    logic       out_load;   // move chain word to output
  } sha_cmd_t;

  localparam logic [1:0] SelData = 2'd0;
  localparam logic [1:0] SelPad  = 2'd1;
  localparam logic [1:0] SelZero = 2'd2;
  localparam logic [1:0] SelLen  = 2'd3;

  typedef struct packed {
    logic [5:0] fill;
  } sha_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
    return (x >> r) | (x << (32 - r));
  endfunction

endpackage
`default_nettype wire

@@ hdl/sha_datapath.sv @@
// sha256 datapath: block store, bit counter, schedule, round unit, chain words
// depends on sha_pkg
`default_nettype none
module sha_datapath import sha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sha_cmd_t    cmd_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [5:0]  rnd_i,
  input  wire logic [2:0]  out_idx_i,
  output sha_stat_t        stat_o,
  output logic [31:0]      word_o
);

  logic [31:0] store_q [16];
  logic [5:0]  fill_q;
  logic [63:0] len_q, len_cap_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [255:0] chain_q;
  logic [31:0] word_q;
  logic [7:0]  wr_byte;
  logic [31:0] rd_word_q;
  logic [3:0]  rd_addr;

  always_comb begin
    case (cmd_i.wr_sel)
      SelData: wr_byte = data_byte_i;
      SelPad:  wr_byte = PadByte;
      SelZero: wr_byte = 8'h00;
      SelLen:  wr_byte = len_cap_q[8*(7-cmd_i.len_idx) +: 8];
      default: wr_byte = 8'h00;
    endcase
  end

  // fetch the word for the next round, word 0 while the block is set up
  assign rd_addr = cmd_i.cmp_start ? 4'd0 : (rnd_i[3:0] + 4'd1);

  // store read one word per cycle, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) store_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= wr_byte;
    rd_word_q <= store_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      len_q   <= '0;
      chain_q <= InitHash;
    end else begin
      if (cmd_i.wr_en) fill_q <= fill_q + 6'd1;
      if (cmd_i.len_clr) len_q <= '0;
      else if (cmd_i.len_add) len_q <= len_q + 64'd8;
      if (cmd_i.chain_init) chain_q <= InitHash;
      else if (cmd_i.cmp_fin) begin
        for (int j = 0; j < 8; j++)
          chain_q[255-32*j -: 32] <= chain_q[255-32*j -: 32] + v_q[j];
      end
    end
  end

  // round logic; schedule word for rounds >= 16 comes from the 16-deep window
  logic [31:0] w15, w2, s0, s1, wt, sig1, ch, t1, sig0, maj, t2;
  always_comb begin
    w15  = w_q[1];
    w2   = w_q[14];
    s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    wt   = (rnd_i < 6'd16) ? rd_word_q : (w_q[0] + s0 + w_q[9] + s1);
    sig1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + sig1 + ch + round_k(rnd_i) + wt;
    sig0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = sig0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_clr) len_cap_q <= len_q;
    if (cmd_i.cmp_start) begin
      for (int j = 0; j < 8; j++) v_q[j] <= chain_q[255-32*j -: 32];
    end else if (cmd_i.rnd_en) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
      for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
      w_q[15] <= wt;
    end
    if (cmd_i.out_load) word_q <= chain_q[255-32*out_idx_i -: 32];
  end

  assign stat_o.fill    = fill_q;
  assign word_o         = word_q;

endmodule
`default_nettype wire

@@ hdl/sha_ctrl.sv @@
// sha256 controller: accepts requests, sequences padding, rounds and digest output
// depends on sha_pkg and the assertion macros
`default_nettype none
`include "sha256_byte_stream_hasher_macros.svh"
module sha_ctrl import sha_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire logic      has_byte_i,
  input  wire logic      end_of_message_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire sha_stat_t stat_i,
  output sha_cmd_t       cmd_o,
  output logic [5:0]     rnd_o,
  output logic [2:0]     idx_o,
  output logic           last_o
);

  typedef enum logic [2:0] {
    StIdle, StPad, StZero, StLen, StPrep, StRound, StFin, StOut
  } state_e;

  state_e     state_q;
  logic [5:0] rnd_q;
  logic [2:0] idx_q;
  logic       closing_q;  // message end pending after this block
  logic       ovalid_q;
  logic       acc;
  // track padding progress across block boundaries
  logic       pad_done_q, prev_len_q;

  assign in_stall_o  = (state_q != StIdle);
  assign acc         = in_valid_i && (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign rnd_o       = rnd_q;
  assign idx_o       = idx_q;
  assign last_o      = (idx_q == 3'd7);

  // state after a store write: full block goes to compression
  function automatic state_e after_write(input logic full, input state_e nxt);
    return full ? StPrep : nxt;
  endfunction

  always_comb begin
    cmd_o = '0;
    cmd_o.wr_sel = SelData;
    cmd_o.len_idx = idx_q;
    case (state_q)
      StIdle: begin
        cmd_o.wr_en   = acc && has_byte_i;
        cmd_o.len_add = acc && has_byte_i;
      end
      StPad: begin
        cmd_o.wr_en = 1'b1; cmd_o.wr_sel = SelPad;
        cmd_o.len_clr = 1'b1;
      end
      StZero: begin
        cmd_o.wr_en = (stat_i.fill != LenOffset); cmd_o.wr_sel = SelZero;
      end
      StLen: begin
        cmd_o.wr_en = 1'b1; cmd_o.wr_sel = SelLen;
      end
      StPrep:  cmd_o.cmp_start = 1'b1;
      StRound: cmd_o.rnd_en = 1'b1;
      StFin:   cmd_o.cmp_fin = 1'b1;
      StOut: begin
        cmd_o.out_load   = !ovalid_q || !out_stall_i;
        cmd_o.chain_init = (!ovalid_q || !out_stall_i) && (idx_q == 3'd7);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      rnd_q      <= '0;
      idx_q      <= '0;
      closing_q  <= 1'b0;
      ovalid_q   <= 1'b0;
      pad_done_q <= 1'b0;
      prev_len_q <= 1'b0;
    end else begin
      if (state_q == StOut && (!ovalid_q || !out_stall_i)) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: if (acc) begin
          closing_q <= end_of_message_i;
          idx_q <= '0;
          if (has_byte_i && stat_i.fill == 6'd63) state_q <= StPrep;
          else if (end_of_message_i) state_q <= StPad;
        end
        StPad: begin
          pad_done_q <= 1'b1;
          state_q <= after_write(stat_i.fill == 6'd63, StZero);
        end
        StZero: begin
          if (stat_i.fill == LenOffset) state_q <= StLen;
          else state_q <= after_write(stat_i.fill == 6'd63, StZero);
        end
        StLen: begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_q <= StPrep;
            closing_q <= 1'b1;
            prev_len_q <= 1'b1;
          end
        end
        StPrep: begin
          rnd_q <= '0;
          state_q <= StRound;
        end
        StRound: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= StFin;
        end
        StFin: begin
          idx_q <= '0;
          // closing_q after the length block means digest time
          if (closing_q && stat_i.fill == 6'd0 && idx_q == 3'd0 && prev_len_q)
            state_q <= StOut;
          else if (closing_q && prev_len_q) state_q <= StOut;
          else if (closing_q && !pad_done_q) state_q <= StPad;
          else if (closing_q) state_q <= StZero;
          else state_q <= StIdle;
        end
        StOut: if (!ovalid_q || !out_stall_i) begin
          if (idx_q == 3'd7) begin
            state_q <= StIdle;
            closing_q <= 1'b0;
            pad_done_q <= 1'b0;
            prev_len_q <= 1'b0;
          end else begin
            idx_q <= idx_q + 3'd1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_stall_busy, clk_i, rst_ni, state_q == StRound, in_stall_o)
  `SHA_ASSERT_NEXT(a_round_wrap, clk_i, rst_ni,
    state_q == StRound && rnd_q == 6'd63, state_q == StFin)
  `SHA_ASSERT_IMP(a_no_write_in_rounds, clk_i, rst_ni, cmd_o.rnd_en, !cmd_o.wr_en)

endmodule
`default_nettype wire

@@ hdl/sha256_byte_stream_hasher.sv @@
// sha256 byte stream hasher top level: controller plus datapath
// depends on sha_pkg, sha_ctrl, sha_datapath
//
// channel | direction | handshake          | payload
// input   | in        | in_valid, in_stall | has_byte, data_byte, end_of_message
// output  | out       | out_valid, out_stall | digest_word, word_index, last_word
//
// a byte is written while idle; a full block then runs 64 rounds on one round unit
// end of message adds padding, one or two blocks, and 8 output words
// reset clears control, bit counter and restores the initial hash
// input stalls while the block is padding, compressing or delivering the digest
`default_nettype none
module sha256_byte_stream_hasher import sha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        has_byte_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  sha_cmd_t   cmd;
  sha_stat_t  stat;
  logic [5:0] rnd;
  logic [2:0] idx;
  logic       last;
  logic [2:0] oidx_q;
  logic       olast_q;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .has_byte_i, .end_of_message_i,
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .stat_i(stat), .cmd_o(cmd), .rnd_o(rnd), .idx_o(idx), .last_o(last)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_byte_i, .rnd_i(rnd),
    .out_idx_i(idx), .stat_o(stat), .word_o(digest_word_o)
  );

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      oidx_q  <= idx;
      olast_q <= last;
    end
  end

  assign word_index_o = oidx_q;
  assign last_word_o  = olast_q;

endmodule
`default_nettype wire
